// ----- src/hsvrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// shared widths, constants and types of the hsv to rgb converter
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  // hue resolution: one degree is 2^HUE_FRAC_BITS hue units
  localparam int HUE_FRAC_BITS = 6;

  localparam int HUE_W  = 15;
  localparam int BYTE_W = 8;
  localparam int SV_W   = 2 * BYTE_W;

  // one 60 degree sector in hue units, written as 15 << SEC_SHIFT
  localparam int SEC_SHIFT    = HUE_FRAC_BITS + 2;
  localparam int SECTOR_UNITS = 60 << HUE_FRAC_BITS;
  localparam int SEC_HI_W     = HUE_W - SEC_SHIFT;

  // two sectors are 15 << MOD_SHIFT, the position inside them is {mod15, low bits}
  localparam int MOD_SHIFT = HUE_FRAC_BITS + 3;
  localparam int POS_W     = MOD_SHIFT + 4;
  localparam int DIST_W    = $clog2(SECTOR_UNITS + 1);
  localparam int PROD_W    = SV_W + DIST_W;

  // every channel ends as floor(q / DIVISOR) with q below 2^QW
  localparam int DIVISOR     = 255 * 15;
  localparam int QW          = 20;
  localparam int RECIP_SHIFT = 32;
  localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / DIVISOR;
  localparam int RECIP_W     = $clog2(RECIP + 1);

  // 60 degree sectors, red to yellow first
  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_t;

endpackage

// ----- src/hsv_to_rgb_converter_unit.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// pixel rate hsv to rgb conversion with alpha pass-through
// ----------------------------------------------------------------------------
// usage:
//   input channel in_*: hue in 1/64 degree units, saturation and brightness
//   as fractions of 255, alpha byte. result channel out_*: red, green, blue
//   bytes, each floor(255 * (component + m)), and the alpha byte unchanged.
//   both channels move an item at an edge with valid high and stall low.
//   path: an accepted item is registered in stages 1 to 4 and then in the
//   output register, which drives out_valid.
//   throughput: one item per cycle while out_stall is low; every stage holds
//   its own valid bit, so an empty stage takes an item while the output stalls.
//   when out_stall holds, items pack into the five stages; in_stall rises
//   only once all of them are full and the output still waits.
//   reset (rst_n low, synchronous) empties every stage; payload registers
//   are not cleared and are ignored until valid.
//   stages: hue sector and triangle distance, s*v products, numerator
//   build, reciprocal multiply, correction plus channel placement.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit
  import hsvrgb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [HUE_W-1:0]  in_hue,
  input  logic [BYTE_W-1:0] in_saturation,
  input  logic [BYTE_W-1:0] in_brightness,
  input  logic [BYTE_W-1:0] in_alpha_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_red,
  output logic [BYTE_W-1:0] out_green,
  output logic [BYTE_W-1:0] out_blue,
  output logic [BYTE_W-1:0] out_alpha_out
);

  // stage enables, each stage moves when empty or when the next one moves
  logic en1, en2, en3, en4, en_out;

  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;

  // ---------------- stage 1: sector, distance to sector edge, s*v
  logic [SEC_HI_W-1:0] hue_sec;
  logic [2:0]          sec_cnt;
  logic [11:0]         hue_hi;
  logic [5:0]          nib_sum;
  logic [3:0]          mod15;
  logic [POS_W-1:0]    pos;
  logic [DIST_W-1:0]   dist_nxt;
  logic [SV_W-1:0]     sv_nxt;

  sector_t           sec1_r;
  logic [DIST_W-1:0] dist1_r;
  logic [SV_W-1:0]   sv1_r;
  logic [BYTE_W-1:0] val1_r, alpha1_r;

  // sector index, count of whole sectors below the hue, stops at the last one
  always_comb begin
    hue_sec = in_hue[HUE_W-1:SEC_SHIFT];
    sec_cnt = 3'd0;
    for (int i = 1; i <= 5; i++) begin
      sec_cnt = sec_cnt + 3'(32'(hue_sec) >= 32'(15 * i));
    end
  end

  // hue mod two sectors: 16 is 1 mod 15, so the nibble sum keeps the residue
  always_comb begin
    hue_hi  = 12'(in_hue >> MOD_SHIFT);
    nib_sum = 6'(hue_hi[3:0]) + 6'(hue_hi[7:4]) + 6'(hue_hi[11:8]);
    if (nib_sum >= 6'd45) begin
      mod15 = 4'(nib_sum - 6'd45);
    end else if (nib_sum >= 6'd30) begin
      mod15 = 4'(nib_sum - 6'd30);
    end else if (nib_sum >= 6'd15) begin
      mod15 = 4'(nib_sum - 6'd15);
    end else begin
      mod15 = 4'(nib_sum);
    end
    pos = {mod15, in_hue[MOD_SHIFT-1:0]};
    if (pos >= POS_W'(SECTOR_UNITS)) begin
      dist_nxt = DIST_W'(pos - POS_W'(SECTOR_UNITS));
    end else begin
      dist_nxt = DIST_W'(POS_W'(SECTOR_UNITS) - pos);
    end
  end

  assign sv_nxt = SV_W'(in_saturation) * SV_W'(in_brightness);

  always_ff @(posedge clk) begin
    if (en1) begin
      sec1_r   <= sector_t'(sec_cnt);
      dist1_r  <= dist_nxt;
      sv1_r    <= sv_nxt;
      val1_r   <= in_brightness;
      alpha1_r <= in_alpha_in;
    end
  end

  // ---------------- stage 2: s*v*dist and the numerator of the zero channel
  logic [PROD_W-1:0] prod_nxt;
  logic [SV_W-1:0]   base_nxt;

  sector_t           sec2_r;
  logic [PROD_W-1:0] prod2_r;
  logic [SV_W-1:0]   base2_r;
  logic [BYTE_W-1:0] val2_r, alpha2_r;

  assign prod_nxt = PROD_W'(sv1_r) * PROD_W'(dist1_r);
  // 255*v - s*v, never negative
  assign base_nxt = SV_W'({val1_r, 8'h00}) - SV_W'(val1_r) - sv1_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      sec2_r   <= sec1_r;
      prod2_r  <= prod_nxt;
      base2_r  <= base_nxt;
      val2_r   <= val1_r;
      alpha2_r <= alpha1_r;
    end
  end

  // ---------------- stage 3: numerators over the divisor
  // x channel: floor((255*v*D - s*v*dist) / 2^SEC_SHIFT) = 3825*v - ceil(s*v*dist / 2^SEC_SHIFT)
  logic [PROD_W:0] prod_up;
  logic [QW-1:0]   qx_nxt, q0_nxt;

  sector_t           sec3_r;
  logic [QW-1:0]     qx3_r, q03_r;
  logic [BYTE_W-1:0] val3_r, alpha3_r;

  assign prod_up = (PROD_W+1)'(prod2_r) + (PROD_W+1)'((1 << SEC_SHIFT) - 1);
  assign qx_nxt  = QW'(val2_r) * QW'(DIVISOR) - QW'(prod_up >> SEC_SHIFT);
  assign q0_nxt  = QW'(base2_r) * QW'(15);

  always_ff @(posedge clk) begin
    if (en3) begin
      sec3_r   <= sec2_r;
      qx3_r    <= qx_nxt;
      q03_r    <= q0_nxt;
      val3_r   <= val2_r;
      alpha3_r <= alpha2_r;
    end
  end

  // ---------------- stage 4: divide both numerators
  logic [BYTE_W-1:0] x_byte, z_byte;

  sector_t           sec4_r;
  logic [BYTE_W-1:0] val4_r, alpha4_r;

  hsvrgb_recip_div u_div_x (
    .clk      (clk),
    .en       (en4),
    .dividend (qx3_r),
    .quotient (x_byte)
  );

  hsvrgb_recip_div u_div_zero (
    .clk      (clk),
    .en       (en4),
    .dividend (q03_r),
    .quotient (z_byte)
  );

  always_ff @(posedge clk) begin
    if (en4) begin
      sec4_r   <= sec3_r;
      val4_r   <= val3_r;
      alpha4_r <= alpha3_r;
    end
  end

  // ---------------- output stage: place chroma (= v), x and zero by sector
  logic [BYTE_W-1:0] red_nxt, green_nxt, blue_nxt;
  logic [BYTE_W-1:0] red_r, green_r, blue_r, alpha_r;

  always_comb begin
    case (sec4_r)
      SEC_R_Y: begin
        red_nxt = val4_r;  green_nxt = x_byte;  blue_nxt = z_byte;
      end
      SEC_Y_G: begin
        red_nxt = x_byte;  green_nxt = val4_r;  blue_nxt = z_byte;
      end
      SEC_G_C: begin
        red_nxt = z_byte;  green_nxt = val4_r;  blue_nxt = x_byte;
      end
      SEC_C_B: begin
        red_nxt = z_byte;  green_nxt = x_byte;  blue_nxt = val4_r;
      end
      SEC_B_M: begin
        red_nxt = x_byte;  green_nxt = z_byte;  blue_nxt = val4_r;
      end
      default: begin
        red_nxt = val4_r;  green_nxt = z_byte;  blue_nxt = x_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha4_r;
    end
  end

  // ---------------- valid bits and stall chain
  assign en_out = !out_valid_r || !out_stall;
  assign en4    = !v4_r || en_out;
  assign en3    = !v3_r || en4;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r        <= in_valid;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en4)    v4_r        <= v3_r;
      if (en_out) out_valid_r <= v4_r;
    end
  end

  assign in_stall      = !en1;
  assign out_valid     = out_valid_r;
  assign out_red       = red_r;
  assign out_green     = green_r;
  assign out_blue      = blue_r;
  assign out_alpha_out = alpha_r;

  // ---------------- checks
  // an empty first stage always takes an item
  a_take_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> !in_stall)
    else $error("input stalled with first stage empty");

  // full pipeline behind a stalled output must push back
  a_full_pushback: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && v1_r && v2_r && v3_r && v4_r) |-> in_stall)
    else $error("input accepted with every stage full");

  // sector count never passes the last sector
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (sec1_r <= SEC_M_R))
    else $error("sector index out of range");

  // zero channel <= x channel <= chroma channel
  a_channel_order: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> ((z_byte <= x_byte) && (x_byte <= val4_r)))
    else $error("channel ordering broken after divide");

endmodule

// ----- src/hsvrgb_recip_div.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_recip_div
// two stage divide by the channel divisor: registered reciprocal product,
// then one compare and correct on the remainder
// ----------------------------------------------------------------------------
module hsvrgb_recip_div
  import hsvrgb_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [QW-1:0]     dividend,
  output logic [BYTE_W-1:0] quotient
);

  localparam int MUL_W = QW + RECIP_W;

  logic [MUL_W-1:0]  mul;
  logic [BYTE_W-1:0] est_r;
  logic [QW-1:0]     dvd_r;
  logic [QW-1:0]     back;
  logic [QW-1:0]     rem;

  // estimate is the true quotient or one below it
  assign mul = MUL_W'(dividend) * MUL_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      est_r <= mul[RECIP_SHIFT +: BYTE_W];
      dvd_r <= dividend;
    end
  end

  assign back     = QW'(est_r) * QW'(DIVISOR);
  assign rem      = dvd_r - back;
  assign quotient = est_r + BYTE_W'(rem >= QW'(DIVISOR));

endmodule

// ----- test/hsv_to_rgb_converter_unit_test.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit_test
// self-checking bench for the pixel rate hsv to rgb converter
// ----------------------------------------------------------------------------
// a short table of directed pixels covers the corners: black, white, the six
// primary and secondary hues, sector boundaries and hue at or past 360
// degrees. about 1850 random pixels follow. a local integer model of the
// conversion predicts red, green and blue for each untyped accepted item, and
// the results are checked in order, field by field. the sender runs in bursts
// with random gaps, and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit_test;
  import hsvrgb_pkg::*;

  // one 60 degree sector in hue units
  localparam longint unsigned SECTOR_SPAN = 64'd60 << HUE_FRAC_BITS;
  localparam int RANDOM_PIXELS = 1850;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
  } rgba_pixel_t;

  // one row of the directed table; typed is set where the answer is obvious
  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [BYTE_W-1:0] sat;
    logic [BYTE_W-1:0] val;
    logic [BYTE_W-1:0] alpha;
    logic              typed;
    rgba_pixel_t       known;
  } hsv_pixel_t;

  // receiver behavior, chosen afresh for each stretch of cycles
  typedef enum logic [1:0] {
    RX_FREE  = 2'd0,
    RX_LIGHT = 2'd1,
    RX_HEAVY = 2'd2,
    RX_HOLD  = 2'd3
  } rx_mode_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [HUE_W-1:0]  in_hue;
  logic [BYTE_W-1:0] in_saturation;
  logic [BYTE_W-1:0] in_brightness;
  logic [BYTE_W-1:0] in_alpha_in;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_red;
  logic [BYTE_W-1:0] out_green;
  logic [BYTE_W-1:0] out_blue;
  logic [BYTE_W-1:0] out_alpha_out;

  // typed answer that travels with the item on the input ports
  logic        drv_typed;
  rgba_pixel_t drv_known;

  rgba_pixel_t  pending_pixels[$];
  rgba_pixel_t  oldest;
  hsv_pixel_t   directed_rows[$];
  int unsigned  failures = 0;
  int unsigned  burst_left = 1;
  int unsigned  rx_left = 0;
  rx_mode_t     rx_mode = RX_FREE;

  hsv_to_rgb_converter_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .in_alpha_in   (in_alpha_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha_out (out_alpha_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // exact rational conversion: every term is a numerator over 255*255*span,
  // each channel is floor((k + m) / (255*span))
  function automatic rgba_pixel_t convert_hsv(input logic [HUE_W-1:0] hue,
                                              input logic [BYTE_W-1:0] sat,
                                              input logic [BYTE_W-1:0] val,
                                              input logic [BYTE_W-1:0] alpha);
    longint unsigned pos, off_peak, ramp, chroma_n, second_n, base_n, denom;
    longint unsigned red_k, green_k, blue_k, sec_idx;
    sector_t         sec;
    rgba_pixel_t     px;
    pos      = longint'(hue) % (2 * SECTOR_SPAN);
    off_peak = (pos >= SECTOR_SPAN) ? pos - SECTOR_SPAN : SECTOR_SPAN - pos;
    ramp     = SECTOR_SPAN - off_peak;
    chroma_n = longint'(sat) * longint'(val) * SECTOR_SPAN;
    second_n = longint'(sat) * longint'(val) * ramp;
    base_n   = 255 * longint'(val) * SECTOR_SPAN - chroma_n;
    denom    = 255 * SECTOR_SPAN;
    // past 360 degrees the sector sticks at magenta to red
    sec_idx  = longint'(hue) / SECTOR_SPAN;
    if (sec_idx > 5) begin
      sec_idx = 5;
    end
    sec = sector_t'(sec_idx[2:0]);
    case (sec)
      SEC_R_Y: begin
        red_k = chroma_n; green_k = second_n; blue_k = 0;
      end
      SEC_Y_G: begin
        red_k = second_n; green_k = chroma_n; blue_k = 0;
      end
      SEC_G_C: begin
        red_k = 0; green_k = chroma_n; blue_k = second_n;
      end
      SEC_C_B: begin
        red_k = 0; green_k = second_n; blue_k = chroma_n;
      end
      SEC_B_M: begin
        red_k = second_n; green_k = 0; blue_k = chroma_n;
      end
      default: begin
        red_k = chroma_n; green_k = 0; blue_k = second_n;
      end
    endcase
    px.red   = BYTE_W'((red_k + base_n) / denom);
    px.green = BYTE_W'((green_k + base_n) / denom);
    px.blue  = BYTE_W'((blue_k + base_n) / denom);
    px.alpha = alpha;
    return px;
  endfunction

  task automatic check_channel(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // predict at the input edge, check at the output edge; pushing first keeps
  // the order fixed within one edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pending_pixels.push_back(drv_typed ? drv_known
                                 : convert_hsv(in_hue, in_saturation, in_brightness,
                                               in_alpha_in));
      end
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          failures++;
          $display("%0t: unexpected result, expected none, actual r %0d g %0d b %0d a %0d",
                   $time, out_red, out_green, out_blue, out_alpha_out);
        end else begin
          oldest = pending_pixels.pop_front();
          check_channel("red", oldest.red, out_red);
          check_channel("green", oldest.green, out_green);
          check_channel("blue", oldest.blue, out_blue);
          check_channel("alpha", oldest.alpha, out_alpha_out);
        end
      end
    end
  end

  // receiver stall pattern: stretches of free flow, light or heavy random
  // stalls, and solid holds, some long enough to fill the pipe
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 24) : $urandom_range(10, 150);
      end
      rx_left--;
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= 1'b1;
      endcase
    end
  end

  // present one item and hold it until accepted; valid stays high into the
  // next item unless the burst ends
  task automatic send_pixel(input hsv_pixel_t px);
    @(negedge clk);
    in_valid      <= 1'b1;
    in_hue        <= px.hue;
    in_saturation <= px.sat;
    in_brightness <= px.val;
    in_alpha_in   <= px.alpha;
    drv_typed     <= px.typed;
    drv_known     <= px.known;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left == 0) begin
      // burst over: a random gap, then a burst of random length
      @(negedge clk);
      in_valid  <= 1'b0;
      drv_typed <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                              : $urandom_range(1, 20);
    end
  endtask

  function automatic logic [BYTE_W-1:0] random_fraction();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  function automatic hsv_pixel_t random_pixel();
    hsv_pixel_t  px;
    int unsigned pick;
    px   = '0;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      px.hue = HUE_W'($urandom_range(0, 23039));
    end else if (pick == 6) begin
      // near a sector boundary, one unit either side
      px.hue = HUE_W'($urandom_range(0, 6) * SECTOR_SPAN + $urandom_range(0, 2));
      if (px.hue != 0) begin
        px.hue = px.hue - 1'b1;
      end
    end else if (pick == 7) begin
      px.hue = HUE_W'($urandom_range(23040, 32767));
    end else begin
      px.hue = HUE_W'($urandom);
    end
    px.sat   = random_fraction();
    px.val   = random_fraction();
    px.alpha = BYTE_W'($urandom);
    return px;
  endfunction

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_hue        = '0;
    in_saturation = '0;
    in_brightness = '0;
    in_alpha_in   = '0;
    drv_typed     = 1'b0;
    drv_known     = '0;

    // hue, sat, val, alpha, typed, {red, green, blue, alpha}
    directed_rows = '{
      // black straight out of reset
      '{15'd0,     8'd0,   8'd0,   8'd0,   1'b1, {8'd0,   8'd0,   8'd0,   8'd0}},
      // pure red, green, blue and the secondaries at full value
      '{15'd0,     8'd255, 8'd255, 8'd255, 1'b1, {8'd255, 8'd0,   8'd0,   8'd255}},
      '{15'd3840,  8'd255, 8'd255, 8'd0,   1'b1, {8'd255, 8'd255, 8'd0,   8'd0}},
      '{15'd7680,  8'd255, 8'd255, 8'h55,  1'b1, {8'd0,   8'd255, 8'd0,   8'h55}},
      '{15'd11520, 8'd255, 8'd255, 8'hAA,  1'b1, {8'd0,   8'd255, 8'd255, 8'hAA}},
      '{15'd15360, 8'd255, 8'd255, 8'd1,   1'b1, {8'd0,   8'd0,   8'd255, 8'd1}},
      '{15'd19200, 8'd255, 8'd255, 8'd254, 1'b1, {8'd255, 8'd0,   8'd255, 8'd254}},
      // no saturation gives grey at value, no value gives black
      '{15'd5000,  8'd0,   8'd255, 8'd7,   1'b1, {8'd255, 8'd255, 8'd255, 8'd7}},
      '{15'd5000,  8'd255, 8'd0,   8'd9,   1'b1, {8'd0,   8'd0,   8'd0,   8'd9}},
      // exactly 360 degrees: sector held at magenta to red, triangle restarts
      '{15'd23040, 8'd255, 8'd255, 8'd3,   1'b1, {8'd255, 8'd0,   8'd0,   8'd3}},
      // last hue below 360, largest hue, far past 360
      '{15'd23039, 8'd255, 8'd255, 8'd10,  1'b0, '0},
      '{15'd32767, 8'd255, 8'd255, 8'd11,  1'b0, '0},
      '{15'd27000, 8'd99,  8'd201, 8'd12,  1'b0, '0},
      // last unit of each sector
      '{15'd3839,  8'd200, 8'd180, 8'd13,  1'b0, '0},
      '{15'd7679,  8'd255, 8'd128, 8'd14,  1'b0, '0},
      '{15'd11519, 8'd1,   8'd255, 8'd15,  1'b0, '0},
      '{15'd15359, 8'd255, 8'd1,   8'd16,  1'b0, '0},
      '{15'd19199, 8'd128, 8'd128, 8'd17,  1'b0, '0},
      // mid sector, top hue bit, near-full fractions
      '{15'd1920,  8'd255, 8'd255, 8'd18,  1'b0, '0},
      '{15'd16384, 8'd170, 8'd85,  8'd19,  1'b0, '0},
      '{15'd1,     8'd254, 8'd254, 8'd20,  1'b0, '0}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i]);
    end
    repeat (RANDOM_PIXELS) begin
      send_pixel(random_pixel());
    end

    @(negedge clk);
    in_valid  <= 1'b0;
    drv_typed <= 1'b0;

    // drain, then a few more edges to catch stray results
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
src/hsvrgb_pkg.sv
src/hsvrgb_recip_div.sv
src/hsv_to_rgb_converter_unit.sv
test/hsv_to_rgb_converter_unit_test.sv
